@@ design/assert_macros.svh @@
// Assertion helpers used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/psrs_pkg.sv @@
package psrs_pkg;

	localparam logic [2:0] EV_ACCEPT = 3'd0;
	localparam logic [2:0] EV_REJECT = 3'd1;
	localparam logic [2:0] EV_IDLE   = 3'd2;
	localparam logic [2:0] EV_RAN    = 3'd3;
	localparam logic [2:0] EV_DONE   = 3'd4;

	typedef struct packed {
		logic        action;
		logic [7:0]  job_id;
		logic [15:0] burst_length;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  running_id;
		logic [31:0] wait_ticks;
		logic [31:0] turnaround_ticks;
		logic [31:0] total_wait;
		logic [31:0] total_turnaround;
		logic [31:0] done_count;
		logic [31:0] now_time;
	} result_t;

	// Candidate that walks down the cell row.
	typedef struct packed {
		logic        found;
		logic [7:0]  job;
		logic [15:0] remaining;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [31:0] waiting;
	} tok_t;

	// Update broadcast to every cell at the end of a scan.
	typedef struct packed {
		logic        wr_arrive;
		logic        wr_tick;
		logic [7:0]  job;
		logic [15:0] burst;
		logic [31:0] stamp;
	} cmd_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

@@ design/preemptive_shortest_remaining_scheduler.sv @@
// Preemptive shortest-remaining-time scheduler. Jobs live in a row of SLOTS cells,
// one job per cell. Each accepted transaction (an arrival or a time tick) launches
// a candidate record at cell 0 that moves one cell per clock; every cell swaps in its
// own job when it beats the record (tick: least remaining, then earlier arrival, then
// lower id, then lower slot) or, for an arrival, when it is the first free cell. Once
// the winner has left the last cell, every cell applies the decision and the result
// is written to the output register; this apply waits while the output register
// still holds an earlier result that is stalled. A new transaction is taken in the
// cycle after the previous one has been written to the output register, even while
// that result still waits to be taken. Slot occupancy uses per-cell valid flags
// cleared by reset, so there is no clearing pass after reset. Totals and done count
// saturate at all ones; the time wraps.
module preemptive_shortest_remaining_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  psrs_pkg::item_t     item,
	output logic                res_valid,
	input  logic                res_stall,
	output psrs_pkg::result_t   res
);
	import psrs_pkg::*;

	`include "assert_macros.svh"

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_CNT = IW'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cnt_q;
	item_t         item_q;
	logic [31:0]   clock_q;
	logic [31:0]   sum_wait_q;
	logic [31:0]   sum_ta_q;
	logic [31:0]   done_q;
	logic          res_valid_q;
	result_t       res_q;

	tok_t          tok_w [SLOTS+1];
	logic [IW-1:0] idx_w [SLOTS+1];
	tok_t          fin;
	logic [IW-1:0] fin_idx;

	logic          accept;
	logic          fire;
	cmd_t          cmd;
	result_t       res_d;
	logic [31:0]   clock_d;
	logic [31:0]   sum_wait_d;
	logic [31:0]   sum_ta_d;
	logic [31:0]   done_d;
	logic [31:0]   ta;
	logic [15:0]   burst_fix;

	// Hold new transactions off while one is in the row.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	// Apply only when the output register is free or being emptied.
	assign fire       = (state_q == ST_APPLY) && (!res_valid_q || !res_stall);

	// Empty candidate enters at the head of the row every cycle.
	assign tok_w[0] = '0;
	assign idx_w[0] = '0;
	assign fin      = tok_w[SLOTS];
	assign fin_idx  = idx_w[SLOTS];

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		psrs_cell #(
			.SLOTS(SLOTS),
			.INDEX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick_mode (item_q.action),
			.tok_in    (tok_w[g]),
			.idx_in    (idx_w[g]),
			.tok_out   (tok_w[g+1]),
			.idx_out   (idx_w[g+1]),
			.cmd       (cmd),
			.cmd_idx   (fin_idx)
		);
	end

	// Sequencer: launch, walk the row, apply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_APPLY: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Decision from the candidate that left the last cell.
	always_comb begin
		burst_fix  = (item_q.burst_length == 16'd0) ? 16'd1 : item_q.burst_length;
		cmd        = '0;
		cmd.job    = item_q.job_id;
		cmd.burst  = burst_fix;
		cmd.stamp  = clock_q;
		clock_d    = clock_q;
		sum_wait_d = sum_wait_q;
		sum_ta_d   = sum_ta_q;
		done_d     = done_q;
		ta         = sat_add32(fin.waiting, {16'd0, fin.burst});
		res_d      = '0;
		if (!item_q.action) begin
			if (fin.found) begin
				cmd.wr_arrive   = fire;
				res_d.event_res = EV_ACCEPT;
			end else begin
				res_d.event_res = EV_REJECT;
			end
		end else begin
			clock_d = clock_q + 32'd1;
			if (!fin.found) begin
				res_d.event_res = EV_IDLE;
			end else begin
				cmd.wr_tick      = fire;
				res_d.running_id = fin.job;
				if (fin.remaining == 16'd1) begin
					res_d.event_res        = EV_DONE;
					res_d.wait_ticks       = fin.waiting;
					res_d.turnaround_ticks = ta;
					sum_wait_d = sat_add32(sum_wait_q, fin.waiting);
					sum_ta_d   = sat_add32(sum_ta_q, ta);
					done_d     = sat_add32(done_q, 32'd1);
				end else begin
					res_d.event_res = EV_RAN;
				end
			end
		end
		res_d.total_wait       = sum_wait_d;
		res_d.total_turnaround = sum_ta_d;
		res_d.done_count       = done_d;
		res_d.now_time         = clock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q    <= '0;
			sum_wait_q <= '0;
			sum_ta_q   <= '0;
			done_q     <= '0;
		end else if (fire) begin
			clock_q    <= clock_d;
			sum_wait_q <= sum_wait_d;
			sum_ta_q   <= sum_ta_d;
			done_q     <= done_d;
		end
	end

	// Output register: load on apply, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_NEXT(a_fire_loads_out, clk, arst_n, fire, res_valid_q,
		"apply did not load output")
	`ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, accept,
		(state_q == ST_SCAN) && (cnt_q == '0), "accepted transaction did not start a scan")
	`ASSERT_NEXT(a_done_only_on_finish, clk, arst_n, fire && (res_d.event_res != EV_DONE),
		done_q == $past(done_q), "done count moved without a completion")
	`ASSERT_ALWAYS(a_no_cmd_outside_apply, clk, arst_n,
		!(cmd.wr_arrive || cmd.wr_tick) || fire, "cell update outside apply")

endmodule

@@ design/psrs_cell.sv @@
module psrs_cell #(
	parameter int SLOTS = 16,
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_mode,
	input  psrs_pkg::tok_t             tok_in,
	input  logic [$clog2(SLOTS)-1:0]   idx_in,
	output psrs_pkg::tok_t             tok_out,
	output logic [$clog2(SLOTS)-1:0]   idx_out,
	input  psrs_pkg::cmd_t             cmd,
	input  logic [$clog2(SLOTS)-1:0]   cmd_idx
);
	import psrs_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic        valid_q;
	logic [7:0]  job_q;
	logic [15:0] rem_q;
	logic [15:0] burst_q;
	logic [31:0] arr_q;
	logic [31:0] wait_q;
	tok_t        tok_q;
	logic [IW-1:0] idx_q;

	logic self_first;
	logic take;
	logic hit;

	// Strictly ahead of the candidate: a full tie keeps the lower slot.
	always_comb begin
		self_first = (rem_q < tok_in.remaining) ||
			((rem_q == tok_in.remaining) && ((arr_q < tok_in.arrival) ||
			((arr_q == tok_in.arrival) && (job_q < tok_in.job))));
		if (tick_mode) begin
			take = valid_q && (!tok_in.found || self_first);
		end else begin
			take = !valid_q && !tok_in.found;
		end
		hit = (cmd_idx == MY_IDX);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q <= '{found: 1'b1, job: job_q, remaining: rem_q, arrival: arr_q,
				burst: burst_q, waiting: wait_q};
			idx_q <= MY_IDX;
		end else begin
			tok_q <= tok_in;
			idx_q <= idx_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.wr_arrive && hit) begin
			valid_q <= 1'b1;
		end else if (cmd.wr_tick && hit && (rem_q == 16'd1)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_arrive && hit) begin
			job_q   <= cmd.job;
			rem_q   <= cmd.burst;
			burst_q <= cmd.burst;
			arr_q   <= cmd.stamp;
			wait_q  <= '0;
		end else if (cmd.wr_tick) begin
			if (hit) begin
				rem_q <= rem_q - 16'd1;
			end else if (valid_q) begin
				wait_q <= sat_add32(wait_q, 32'd1);
			end
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule
